>>> sv/kvcl_pkg.sv
package kvcl_pkg;

    typedef enum logic [4:0] {
        S_ERR   = 5'd1,
        S_BEGIN = 5'd2,
        S_COMM  = 5'd3,
        S_KEY   = 5'd4,
        S_KBS   = 5'd5,
        S_KBX1  = 5'd6,
        S_KBX2  = 5'd7,
        S_KSQ   = 5'd8,
        S_KDQ   = 5'd9,
        S_KDQBS = 5'd10,
        S_KDQX1 = 5'd11,
        S_KDQX2 = 5'd12,
        S_BEQ   = 5'd13,
        S_AEQ   = 5'd14,
        S_VAL   = 5'd15,
        S_VBS   = 5'd16,
        S_VBX1  = 5'd17,
        S_VBX2  = 5'd18,
        S_VSQ   = 5'd19,
        S_VDQ   = 5'd20,
        S_VDQBS = 5'd21,
        S_VDQX1 = 5'd22,
        S_VDQX2 = 5'd23,
        S_VEND  = 5'd24
    } state_t;

    typedef enum logic [2:0] {
        A_NONE   = 3'd0,
        A_KEYEND = 3'd1,
        A_VALEND = 3'd2,
        A_ERR    = 3'd3,
        A_STORE  = 3'd4,
        A_MOD    = 3'd5,
        A_HEX1   = 3'd6,
        A_HEX2   = 3'd7
    } action_t;

    localparam logic [2:0] K_KEYCH  = 3'd0;
    localparam logic [2:0] K_VALCH  = 3'd1;
    localparam logic [2:0] K_KEYEND = 3'd2;
    localparam logic [2:0] K_VALEND = 3'd3;
    localparam logic [2:0] K_ERROR  = 3'd4;

    localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
    localparam logic [15:0] COL_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_char;
        logic        chunk_full;
        logic [23:0] line_no;
        logic [15:0] column_no;
    } out_word_t;

    // classified event handed from front to back
    typedef struct packed {
        action_t     act;
        logic        is_val;
        logic [7:0]  ch;
        logic [23:0] line_no;
        logic [15:0] column_no;
    } evt_t;

endpackage

>>> sv/key_value_config_lexer.sv
// key_value_config_lexer: streaming tokenizer for key = value text.
// An accepted word is held in the front's event register, then in the back's output register.
// Throughput: one word per cycle while the output is not stalled, set by the combinational state lookup.
// Reset (rst_n low, asynchronous): begin state, line and column 1,
// chunk count and hex digit cleared, no word pending.
module key_value_config_lexer #(
    parameter int CHUNK_SIZE = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  kvcl_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output kvcl_pkg::out_word_t out_data
);
    import kvcl_pkg::*;

    // front: classify each byte, track position; back: chunk count, format
    evt_t ev_data;
    logic ev_valid, ev_ready;

    kvcl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .ev_valid (ev_valid),
        .ev_ready (ev_ready),
        .ev_data  (ev_data)
    );

    kvcl_back #(.CHUNK_SIZE(CHUNK_SIZE)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev_valid  (ev_valid),
        .ev_ready  (ev_ready),
        .ev_data   (ev_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );
endmodule

>>> sv/kvcl_front.sv
module kvcl_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  kvcl_pkg::in_word_t in_data,
    output logic               ev_valid,
    input  logic               ev_ready,
    output kvcl_pkg::evt_t     ev_data
);
    import kvcl_pkg::*;

    state_t      state_reg, state_next;
    logic [3:0]  hex_reg, hex_next;
    logic [23:0] line_reg, line_next;
    logic [15:0] col_reg, col_next;
    logic        ev_valid_reg, ev_valid_next;
    evt_t        ev_reg, ev_next;
    action_t     act;
    state_t      nx;
    logic [7:0]  c, dch;
    logic        ws, hx, esc;
    logic [3:0]  hv;
    logic        acc;

    function automatic logic [3:0] hexval(input logic [7:0] x);
        logic [3:0] r;
        r = 4'd0;
        if (x >= "0" && x <= "9") r = 4'(x - "0");
        else if (x >= "a" && x <= "f") r = 4'(x - "a" + 8'd10);
        else if (x >= "A" && x <= "F") r = 4'(x - "A" + 8'd10);
        return r;
    endfunction

    assign c   = in_data.in_byte;
    assign ws  = c inside {8'h20, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h0B};
    assign hx  = c inside {["0":"9"], ["a":"f"], ["A":"F"]};
    assign esc = c inside {"f", "n", "r", "t", "v"};
    assign hv  = hexval(c);

    assign in_ready = !ev_valid_reg || ev_ready;
    assign acc      = in_valid && in_ready;
    assign ev_valid = ev_valid_reg;
    assign ev_data  = ev_reg;

    always_comb
    begin
        act = A_NONE;
        nx  = S_ERR;
        case (state_reg)
            S_BEGIN:
            begin
                if (ws) nx = S_BEGIN;
                else if (c == ";" || c == "=") act = A_ERR;
                else if (c == "#") nx = S_COMM;
                else if (c == "'") nx = S_KSQ;
                else if (c == "\"") nx = S_KDQ;
                else if (c == "\\") nx = S_KBS;
                else begin nx = S_KEY; act = A_STORE; end
            end
            S_COMM: nx = (c == 8'h0A) ? S_BEGIN : S_COMM;
            S_KEY:
            begin
                if (ws) begin nx = S_BEQ; act = A_KEYEND; end
                else if (c == "'") nx = S_KSQ;
                else if (c == "\"") nx = S_KDQ;
                else if (c == ";" || c == "#") act = A_ERR;
                else if (c == "=") begin nx = S_AEQ; act = A_KEYEND; end
                else if (c == "\\") nx = S_KBS;
                else begin nx = S_KEY; act = A_STORE; end
            end
            S_BEQ:
            begin
                if (ws) nx = S_BEQ;
                else if (c == "=") nx = S_AEQ;
                else act = A_ERR;
            end
            S_AEQ:
            begin
                if (ws) nx = S_AEQ;
                else if (c == "'") nx = S_VSQ;
                else if (c == "\"") nx = S_VDQ;
                else if (c == "\\") nx = S_VBS;
                else if (c == "=") act = A_ERR;
                else if (c == "#") begin nx = S_COMM; act = A_VALEND; end
                else if (c == ";") begin nx = S_BEGIN; act = A_VALEND; end
                else begin nx = S_VAL; act = A_STORE; end
            end
            S_VAL:
            begin
                if (c == 8'h0A || c == ";") begin nx = S_BEGIN; act = A_VALEND; end
                else if (ws) begin nx = S_VEND; act = A_VALEND; end
                else if (c == "'") nx = S_VSQ;
                else if (c == "\"") nx = S_VDQ;
                else if (c == "=") act = A_ERR;
                else if (c == "#") begin nx = S_COMM; act = A_VALEND; end
                else if (c == "\\") nx = S_VBS;
                else begin nx = S_VAL; act = A_STORE; end
            end
            S_VEND:
            begin
                if (c == 8'h0A || c == ";") nx = S_BEGIN;
                else if (ws) nx = S_VEND;
                else if (c == "#") nx = S_COMM;
                else act = A_ERR;
            end
            S_KBS, S_KDQBS, S_VBS, S_VDQBS:
            begin
                if (state_reg == S_KBS) nx = S_KEY;
                else if (state_reg == S_VBS) nx = S_VAL;
                else if (state_reg == S_KDQBS) nx = S_KDQ;
                else nx = S_VDQ;
                if (esc) act = A_MOD;
                else if (c == "x") nx = state_t'(state_reg + 5'd1);
                else if (c != 8'h0A) act = A_STORE;
            end
            S_KBX1, S_KDQX1, S_VBX1, S_VDQX1:
            begin
                if (hx) begin nx = state_t'(state_reg + 5'd1); act = A_HEX1; end
                else act = A_ERR;
            end
            S_KBX2, S_KDQX2, S_VBX2, S_VDQX2:
            begin
                if (!hx) act = A_ERR;
                else
                begin
                    act = A_HEX2;
                    if (state_reg == S_KBX2) nx = S_KEY;
                    else if (state_reg == S_VBX2) nx = S_VAL;
                    else if (state_reg == S_KDQX2) nx = S_KDQ;
                    else nx = S_VDQ;
                end
            end
            S_KSQ, S_VSQ:
            begin
                if (c == "'") nx = (state_reg == S_KSQ) ? S_KEY : S_VAL;
                else begin nx = state_reg; act = A_STORE; end
            end
            S_KDQ, S_VDQ:
            begin
                if (c == "\"") nx = (state_reg == S_KDQ) ? S_KEY : S_VAL;
                else if (c == "\\") nx = (state_reg == S_KDQ) ? S_KDQBS : S_VDQBS;
                else begin nx = state_reg; act = A_STORE; end
            end
            default: act = A_ERR;
        endcase
    end

    always_comb
    begin
        case (c)
            "f":     dch = 8'h0C;
            "n":     dch = 8'h0A;
            "r":     dch = 8'h0D;
            "t":     dch = 8'h09;
            default: dch = 8'h0B;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        hex_next      = hex_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        ev_valid_next = ev_valid_reg && !ev_ready;
        ev_next       = ev_reg;
        if (acc)
        begin
            ev_next.line_no   = line_reg;
            ev_next.column_no = col_reg;
            ev_next.is_val    = 1'b0;
            ev_next.ch        = 8'd0;
            if (in_data.end_of_input)
            begin
                // report position only; state untouched
                ev_valid_next = !(state_reg == S_BEGIN || state_reg == S_COMM
                                  || state_reg == S_VEND);
                ev_next.act = (state_reg == S_AEQ || state_reg == S_VAL) ? A_VALEND : A_ERR;
            end
            else
            begin
                state_next    = nx;
                ev_valid_next = (act != A_NONE) && (act != A_HEX1);
                ev_next.act   = act;
                ev_next.is_val = nx > S_KDQX2;
                if (act == A_HEX1) hex_next = hv;
                if (act == A_MOD) ev_next.ch = dch;
                else if (act == A_HEX2) ev_next.ch = {hex_reg, hv};
                else ev_next.ch = c;
                if (c == 8'h0A)
                begin
                    if (line_reg < LINE_MAX) line_next = line_reg + 24'd1;
                    col_next = 16'd1;
                end
                else if (col_reg < COL_MAX) col_next = col_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_BEGIN;
            hex_reg      <= 4'd0;
            line_reg     <= 24'd1;
            col_reg      <= 16'd1;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            hex_reg      <= hex_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            ev_valid_reg <= ev_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg <= ev_next;
    end
endmodule

>>> sv/kvcl_back.sv
module kvcl_back #(
    parameter int CHUNK_SIZE = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ev_valid,
    output logic                ev_ready,
    input  kvcl_pkg::evt_t      ev_data,
    output logic                out_valid,
    input  logic                out_ready,
    output kvcl_pkg::out_word_t out_data
);
    import kvcl_pkg::*;

    localparam logic [7:0] CHUNK = 8'(CHUNK_SIZE);

    logic [7:0] cnt_reg, cnt_next, cnt_inc;
    logic       ov_reg, ov_next;
    out_word_t  od_reg, od_next;
    logic       acc, is_store;

    assign ev_ready  = !ov_reg || out_ready;
    assign acc       = ev_valid && ev_ready;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign is_store  = ev_data.act == A_STORE || ev_data.act == A_MOD
                       || ev_data.act == A_HEX2;
    assign cnt_inc   = cnt_reg + 8'd1;

    always_comb
    begin
        cnt_next = cnt_reg;
        ov_next  = ov_reg && !out_ready;
        od_next  = od_reg;
        if (acc)
        begin
            ov_next           = 1'b1;
            od_next.line_no   = ev_data.line_no;
            od_next.column_no = ev_data.column_no;
            od_next.out_char  = 8'd0;
            od_next.chunk_full = 1'b0;
            cnt_next          = 8'd0;
            case (ev_data.act)
                A_KEYEND: od_next.kind = K_KEYEND;
                A_VALEND: od_next.kind = K_VALEND;
                default:  od_next.kind = K_ERROR;
            endcase
            if (is_store)
            begin
                od_next.kind     = ev_data.is_val ? K_VALCH : K_KEYCH;
                od_next.out_char = ev_data.ch;
                if (cnt_inc >= CHUNK) od_next.chunk_full = 1'b1;
                else cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 8'd0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
    end
endmodule

>>> sim/key_value_config_lexer_tb.sv
module key_value_config_lexer_tb;
    import kvcl_pkg::*;

    localparam int CHUNK = 128;
    localparam int IDLE_PCT = 36;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_word_t in_data;
    logic out_valid;
    logic out_ready;
    out_word_t out_data;

    key_value_config_lexer #(.CHUNK_SIZE(CHUNK)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Lexer mirror state
    state_t      lx_state;
    logic [3:0]  lx_hex_high;
    logic [7:0]  lx_chunk;
    logic [23:0] lx_line;
    logic [15:0] lx_col;

    in_word_t  text_q[$];
    out_word_t token_q[$];
    int  errors;
    int  idle_pct_in;
    int  idle_pct_out;
    bit  out_hold;
    bit  in_pause;
    int  quiet_cycles;
    bit  done;

    function automatic bit is_space(logic [7:0] c);
        return c == 8'h20 || c == 8'h0c || c == 8'h0a || c == 8'h0d || c == 8'h09 ||
               c == 8'h0b;
    endfunction

    function automatic bit is_hexdig(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_nibble(logic [7:0] c);
        if (c >= "0" && c <= "9") return 4'(c - "0");
        if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
        if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
        return 4'd0;
    endfunction

    function automatic bit is_escape(logic [7:0] c);
        return c == "f" || c == "n" || c == "r" || c == "t" || c == "v";
    endfunction

    function automatic logic [7:0] escape_char(logic [7:0] c);
        case (c)
            "f": return 8'h0c;
            "n": return 8'h0a;
            "r": return 8'h0d;
            "t": return 8'h09;
            default: return 8'h0b;
        endcase
    endfunction

    function automatic bit in_value(state_t s);
        return s >= S_VBS && s <= S_VDQX2;
    endfunction

    // Work out the next state and action for one byte.
    task automatic next_state(input state_t st, input logic [7:0] c,
                              output state_t nx, output action_t act);
        state_t base;
        state_t home;
        bit     val;
        nx  = S_ERR;
        act = A_NONE;
        val = in_value(st);
        home = val ? S_VAL : S_KEY;
        case (st)
            S_BEGIN:
            begin
                if (is_space(c)) nx = S_BEGIN;
                else if (c == ";" || c == "=") act = A_ERR;
                else if (c == "#") nx = S_COMM;
                else if (c == "'") nx = S_KSQ;
                else if (c == "\"") nx = S_KDQ;
                else if (c == "\\") nx = S_KBS;
                else begin nx = S_KEY; act = A_STORE; end
            end
            S_COMM: nx = (c == 8'h0a) ? S_BEGIN : S_COMM;
            S_KEY:
            begin
                if (is_space(c)) begin nx = S_BEQ; act = A_KEYEND; end
                else if (c == "'") nx = S_KSQ;
                else if (c == "\"") nx = S_KDQ;
                else if (c == ";" || c == "#") act = A_ERR;
                else if (c == "=") begin nx = S_AEQ; act = A_KEYEND; end
                else if (c == "\\") nx = S_KBS;
                else begin nx = S_KEY; act = A_STORE; end
            end
            S_BEQ:
            begin
                if (is_space(c)) nx = S_BEQ;
                else if (c == "=") nx = S_AEQ;
                else act = A_ERR;
            end
            S_AEQ:
            begin
                if (is_space(c)) nx = S_AEQ;
                else if (c == "'") nx = S_VSQ;
                else if (c == "\"") nx = S_VDQ;
                else if (c == "\\") nx = S_VBS;
                else if (c == "=") act = A_ERR;
                else if (c == "#") begin nx = S_COMM; act = A_VALEND; end
                else if (c == ";") begin nx = S_BEGIN; act = A_VALEND; end
                else begin nx = S_VAL; act = A_STORE; end
            end
            S_VAL:
            begin
                if (c == 8'h0a || c == ";") begin nx = S_BEGIN; act = A_VALEND; end
                else if (is_space(c)) begin nx = S_VEND; act = A_VALEND; end
                else if (c == "'") nx = S_VSQ;
                else if (c == "\"") nx = S_VDQ;
                else if (c == "=") act = A_ERR;
                else if (c == "#") begin nx = S_COMM; act = A_VALEND; end
                else if (c == "\\") nx = S_VBS;
                else begin nx = S_VAL; act = A_STORE; end
            end
            S_VEND:
            begin
                if (c == 8'h0a || c == ";") nx = S_BEGIN;
                else if (is_space(c)) nx = S_VEND;
                else if (c == "#") nx = S_COMM;
                else act = A_ERR;
            end
            S_KBS, S_VBS, S_KDQBS, S_VDQBS:
            begin
                base = (st == S_KBS || st == S_VBS) ? home : (val ? S_VDQ : S_KDQ);
                if (is_escape(c)) begin nx = base; act = A_MOD; end
                else if (c == "x")
                begin
                    if (st == S_KBS) nx = S_KBX1;
                    else if (st == S_VBS) nx = S_VBX1;
                    else if (st == S_KDQBS) nx = S_KDQX1;
                    else nx = S_VDQX1;
                end
                else if (c == 8'h0a) nx = base;
                else begin nx = base; act = A_STORE; end
            end
            S_KBX1, S_VBX1, S_KDQX1, S_VDQX1:
            begin
                if (is_hexdig(c)) begin nx = state_t'(st + 5'd1); act = A_HEX1; end
                else act = A_ERR;
            end
            S_KBX2, S_VBX2:
            begin
                if (is_hexdig(c)) begin nx = home; act = A_HEX2; end
                else act = A_ERR;
            end
            S_KDQX2, S_VDQX2:
            begin
                if (is_hexdig(c)) begin nx = val ? S_VDQ : S_KDQ; act = A_HEX2; end
                else act = A_ERR;
            end
            S_KSQ, S_VSQ:
            begin
                if (c == "'") nx = home;
                else begin nx = st; act = A_STORE; end
            end
            S_KDQ, S_VDQ:
            begin
                if (c == "\"") nx = home;
                else if (c == "\\") nx = val ? S_VDQBS : S_KDQBS;
                else begin nx = st; act = A_STORE; end
            end
            default: act = A_ERR;
        endcase
    endtask

    // Apply one accepted word to the mirror and queue any token it yields.
    task automatic lex_word(input in_word_t w);
        state_t    nx;
        action_t   act;
        out_word_t t;
        logic [7:0] c;
        c = w.in_byte;
        t = '0;
        t.line_no = lx_line;
        t.column_no = lx_col;
        if (w.end_of_input)
        begin
            if (lx_state == S_BEGIN || lx_state == S_COMM || lx_state == S_VEND) return;
            lx_chunk = 8'd0;
            t.kind = (lx_state == S_AEQ || lx_state == S_VAL) ? K_VALEND : K_ERROR;
            token_q.push_back(t);
            return;
        end
        next_state(lx_state, c, nx, act);
        lx_state = nx;
        case (act)
            A_KEYEND, A_VALEND, A_ERR:
            begin
                lx_chunk = 8'd0;
                t.kind = (act == A_KEYEND) ? K_KEYEND : (act == A_VALEND) ? K_VALEND : K_ERROR;
                token_q.push_back(t);
            end
            A_HEX1: lx_hex_high = hex_nibble(c);
            A_STORE, A_MOD, A_HEX2:
            begin
                if (act == A_MOD) t.out_char = escape_char(c);
                else if (act == A_HEX2) t.out_char = {lx_hex_high, hex_nibble(c)};
                else t.out_char = c;
                lx_chunk = lx_chunk + 8'd1;
                if (lx_chunk >= CHUNK)
                begin
                    t.chunk_full = 1'b1;
                    lx_chunk = 8'd0;
                end
                t.kind = (nx <= S_KDQX2) ? K_KEYCH : K_VALCH;
                token_q.push_back(t);
            end
            default: ;
        endcase
        // advance position after reporting
        if (c == 8'h0a)
        begin
            if (lx_line != LINE_MAX) lx_line = lx_line + 24'd1;
            lx_col = 16'd1;
        end
        else if (lx_col != COL_MAX)
        begin
            lx_col = lx_col + 16'd1;
        end
    endtask

    task automatic report(input string what, input out_word_t got, input out_word_t want);
        errors++;
        $display("ERROR %s: got %h want %h", what, got, want);
    endtask

    // Driver: offer the head of the pending text, hold until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                lex_word(in_data);
            end
            if (!in_valid || in_ready)
            begin
                if (text_q.size() > 0 && !in_pause &&
                    $urandom_range(99, 0) >= idle_pct_in)
                begin
                    in_valid <= 1'b1;
                    in_data  <= text_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted token with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (token_q.size() == 0)
                    report("unexpected token", out_data, '0);
                else if (out_data !== token_q[0])
                    report("token field", out_data, token_q.pop_front());
                else
                    void'(token_q.pop_front());
            end
            out_ready <= !out_hold && ($urandom_range(99, 0) >= idle_pct_out);
        end
    end

    // Watchdog on cycles with no accepted word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if (!done)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("key_value_config_lexer: mismatch");
                $finish;
            end
        end
    end

    task automatic put_byte(input logic [7:0] c);
        in_word_t w;
        w.in_byte = c;
        w.end_of_input = 1'b0;
        text_q.push_back(w);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic put_end(input logic [7:0] junk);
        in_word_t w;
        w.in_byte = junk;
        w.end_of_input = 1'b1;
        text_q.push_back(w);
    endtask

    task automatic wait_drained();
        while (text_q.size() > 0 || in_valid || token_q.size() > 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55) return 8'($urandom_range(122, 97));
        if (r < 65) return 8'($urandom_range(57, 48));
        if (r < 75) return 8'($urandom_range(255, 128));
        case ($urandom_range(9, 0))
            0: return " ";
            1: return "\\";
            2: return "\"";
            3: return "'";
            4: return "=";
            5: return ";";
            6: return "#";
            7: return 8'h0a;
            8: return "x";
            default: return 8'($urandom_range(255, 0));
        endcase
    endfunction

    // Emit a token body with random escapes and quotes.
    task automatic put_token(input int len);
        logic [7:0] hexd[16] = '{"0","1","2","3","4","5","6","7","8","9",
                                 "a","b","c","D","E","F"};
        string esc_set = "fnrtv\n?";
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(9, 0))
                0: begin put_byte("\\"); put_byte("x");
                         put_byte(hexd[$urandom_range(15, 0)]);
                         put_byte(hexd[$urandom_range(15, 0)]); end
                1: begin put_byte("\\"); put_byte(esc_set[$urandom_range(6, 0)]); end
                2: begin put_byte("'"); put_byte(8'($urandom_range(255, 0)));
                         put_byte(" "); put_byte("'"); end
                3: begin put_byte("\""); put_byte(8'($urandom_range(255, 128)));
                         put_byte("\\"); put_byte("t"); put_byte("\""); end
                default: put_byte(8'($urandom_range(122, 97)));
            endcase
        end
    endtask

    task automatic put_line();
        int r;
        r = $urandom_range(99, 0);
        if (r < 10) begin put_text("# note "); put_byte(pick_char()); put_byte(8'h0a); return; end
        if (r < 20)
        begin
            for (int i = 0; i < $urandom_range(6, 1); i++) put_byte(pick_char());
            if ($urandom_range(3, 0) == 0) put_end(8'($urandom_range(255, 0)));
            return;
        end
        put_token($urandom_range(5, 1));
        put_text($urandom_range(1, 0) ? " = " : "=");
        put_token($urandom_range(6, 0));
        case ($urandom_range(4, 0))
            0: put_byte(";");
            1: put_text(" # c\n");
            2: put_text("  \n");
            default: put_byte(8'h0a);
        endcase
    endtask

    initial
    begin
        rst_n = 1'b0;
        lx_state = S_BEGIN;
        lx_hex_high = 4'd0;
        lx_chunk = 8'd0;
        lx_line = 24'd1;
        lx_col = 16'd1;
        errors = 0;
        idle_pct_in = IDLE_PCT;
        idle_pct_out = IDLE_PCT;
        out_hold = 1'b0;
        in_pause = 1'b0;
        done = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: escapes, quotes, hex, continuation, comments, end marks
        put_text("k\\x4F\\n='a b'\\\n\"q\\xfF\\\"\"; #c\n");
        put_text("v = x\\\\ \n");
        put_byte(8'h00); put_byte(8'hff); put_text("=");
        put_end(8'hff);
        put_byte(8'h0a); put_text("=;"); put_end(8'h00);
        wait_drained();

        // sender pause until all tokens are back, then a receiver stall
        in_pause = 1'b1;
        wait_drained();
        out_hold = 1'b1;
        in_pause = 1'b0;
        for (int i = 0; i < 6; i++) put_line();
        repeat (60) @(posedge clk);
        out_hold = 1'b0;
        wait_drained();

        // long key to fill chunks
        put_text("\n");
        for (int i = 0; i < 2 * CHUNK + 3; i++) put_byte(8'($urandom_range(122, 97)));
        put_text("=v\n");

        // random text, no idling on the first stretch
        idle_pct_in = 0;
        idle_pct_out = 0;
        for (int i = 0; i < 12; i++) put_line();
        wait_drained();
        idle_pct_in = IDLE_PCT;
        idle_pct_out = IDLE_PCT;
        put_byte(8'h0a);
        while (text_q.size() < 350)
        begin
            put_line();
            if ($urandom_range(29, 0) == 0) put_byte(8'h0a);
        end
        wait_drained();
        repeat (10) @(posedge clk);
        done = 1'b1;
        if (errors == 0)
            $display("key_value_config_lexer: match");
        else
            $display("key_value_config_lexer: mismatch");
        $finish;
    end
endmodule

>>> files.f
sv/kvcl_pkg.sv
sv/kvcl_front.sv
sv/kvcl_back.sv
sv/key_value_config_lexer.sv
sim/key_value_config_lexer_tb.sv
